// ===== src/tlr_pkg.sv =====
// ----------------------------------------------------------------------------
// tlr_pkg
// shared widths, limits, queue entry type and helpers for the thick line
// rasterizer
// ----------------------------------------------------------------------------
package tlr_pkg;

  localparam int unsigned COORD_W    = 11;
  localparam int unsigned RES_W      = 12;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned RAD_W      = 3;
  localparam int unsigned MAX_RADIUS = 4;
  localparam int unsigned OFF_W      = 4;
  localparam int unsigned SQ_W       = 6;
  localparam int unsigned MAX_RES    = 2048;
  localparam int unsigned MIN_RES    = 64;
  localparam int unsigned RES_RESET  = 512;
  localparam int unsigned ERR_W      = 13;
  localparam int unsigned DYN_W      = 12;
  localparam int unsigned QDEPTH     = 2;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e               kind;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic [COLOR_W-1:0] color;
    logic [RAD_W-1:0]   radius;
  } cmd_t;

  // square of a small signed offset
  function automatic logic [SQ_W-1:0] off_sq(logic signed [OFF_W-1:0] v);
    logic [OFF_W-1:0] mag;
    mag = v[OFF_W-1] ? OFF_W'(-v) : OFF_W'(v);
    return SQ_W'(SQ_W'(mag) * SQ_W'(mag));
  endfunction

endpackage

// ===== src/tlr_front.sv =====
// ----------------------------------------------------------------------------
// tlr_front
// input side: decodes the operation, saturates the brush radius and pushes
// the item into the command queue
// ----------------------------------------------------------------------------
module tlr_front (
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [tlr_pkg::COORD_W-1:0]  start_x_i,
  input  logic [tlr_pkg::COORD_W-1:0]  start_y_i,
  input  logic [tlr_pkg::COORD_W-1:0]  end_x_i,
  input  logic [tlr_pkg::COORD_W-1:0]  end_y_i,
  input  logic [tlr_pkg::COLOR_W-1:0]  line_color_i,
  input  logic [tlr_pkg::RAD_W-1:0]    brush_radius_i,
  output logic                         push_o,
  output tlr_pkg::cmd_t                cmd_o,
  input  logic                         full_i
);
  import tlr_pkg::*;

  always_comb begin
    cmd_o.kind   = operation_i ? CMD_STEP : CMD_LOAD;
    cmd_o.sx     = start_x_i;
    cmd_o.sy     = start_y_i;
    cmd_o.ex     = end_x_i;
    cmd_o.ey     = end_y_i;
    cmd_o.color  = line_color_i;
    cmd_o.radius = (brush_radius_i > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                         : brush_radius_i;
  end

  assign push_o     = in_valid_i && !full_i;
  assign in_stall_o = full_i;

endmodule

// ===== src/tlr_queue.sv =====
// ----------------------------------------------------------------------------
// tlr_queue
// short command queue between the front and the back engine
// ----------------------------------------------------------------------------
module tlr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tlr_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          valid_o,
  output tlr_pkg::cmd_t cmd_o,
  input  logic          pop_i
);
  import tlr_pkg::*;

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  cmd_t             mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== src/tlr_back.sv =====
// ----------------------------------------------------------------------------
// tlr_back
// back engine: holds the line state, scans the disc one offset per cycle unless
// output back-pressure holds it, buffers one hit to mark the last write and
// walks the bresenham step
module tlr_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  tlr_pkg::cmd_t                cmd_i,
  output logic                         cmd_pop_o,
  input  logic [tlr_pkg::RES_W-1:0]    res_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tlr_pkg::COORD_W-1:0]  pixel_x_o,
  output logic [tlr_pkg::COORD_W-1:0]  pixel_y_o,
  output logic [tlr_pkg::COLOR_W-1:0]  pixel_color_o,
  output logic                         write_enable_o,
  output logic                         last_of_point_o,
  output logic                         line_done_o
);
  import tlr_pkg::*;

  localparam int unsigned PX_W = COORD_W + 2;
  localparam int unsigned TW_W = ERR_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;

  logic [COORD_W-1:0]      cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COORD_W-1:0]      tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [COORD_W-1:0]      dx_q, dx_d;
  logic signed [DYN_W-1:0] dyn_q, dyn_d;
  logic                    sxn_q, sxn_d, syn_q, syn_d;
  logic signed [ERR_W-1:0] err_q, err_d;
  logic [COLOR_W-1:0]      color_q, color_d;
  logic [RAD_W-1:0]        rad_q, rad_d;
  logic                    active_q, active_d;
  logic                    done_q, done_d;
  logic signed [OFF_W-1:0] ox_q, ox_d, oy_q, oy_d;
  logic                    pend_v_q, pend_v_d;
  logic [COORD_W-1:0]      pend_x_q, pend_x_d, pend_y_q, pend_y_d;
  logic                    out_v_q, out_v_d;
  logic [COORD_W-1:0]      out_x_q, out_x_d, out_y_q, out_y_d;
  logic [COLOR_W-1:0]      out_c_q, out_c_d;
  logic                    out_we_q, out_we_d, out_last_q, out_last_d;
  logic                    out_done_q, out_done_d;

  logic signed [OFF_W-1:0] r_off;
  logic [SQ_W:0]           dist_sq, rad_sq;
  logic signed [PX_W-1:0]  px, py;
  logic                    in_x, in_y, hit, last_off, out_free, can_go;

  logic signed [TW_W-1:0]  twice, dyn_ext, dx_ext;
  logic                    step_x, step_y;
  logic [COORD_W-1:0]      dx_ld, dy_ld;

  assign r_off    = OFF_W'(rad_q);
  assign dist_sq  = {1'b0, off_sq(ox_q)} + {1'b0, off_sq(oy_q)};
  assign rad_sq   = {1'b0, off_sq(r_off)};
  assign px       = $signed({2'b00, cur_x_q}) + $signed({{(PX_W-OFF_W){ox_q[OFF_W-1]}}, ox_q});
  assign py       = $signed({2'b00, cur_y_q}) + $signed({{(PX_W-OFF_W){oy_q[OFF_W-1]}}, oy_q});
  assign in_x     = !px[PX_W-1] && (px[RES_W-1:0] < res_i);
  assign in_y     = !py[PX_W-1] && (py[RES_W-1:0] < res_i);
  assign hit      = (dist_sq <= rad_sq) && in_x && in_y;
  assign last_off = (ox_q == r_off) && (oy_q == r_off);
  assign out_free = !out_v_q || !out_stall_i;
  assign can_go   = !(hit && pend_v_q) || out_free;

  assign twice   = {err_q, 1'b0};
  assign dyn_ext = {{(TW_W-DYN_W){dyn_q[DYN_W-1]}}, dyn_q};
  assign dx_ext  = {{(TW_W-COORD_W){1'b0}}, dx_q};
  assign step_x  = (twice >= dyn_ext);
  assign step_y  = (twice <= dx_ext);

  assign dx_ld = (cmd_i.ex > cmd_i.sx) ? cmd_i.ex - cmd_i.sx : cmd_i.sx - cmd_i.ex;
  assign dy_ld = (cmd_i.ey > cmd_i.sy) ? cmd_i.ey - cmd_i.sy : cmd_i.sy - cmd_i.ey;

  always_comb begin
    state_d    = state_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    tgt_x_d    = tgt_x_q;
    tgt_y_d    = tgt_y_q;
    dx_d       = dx_q;
    dyn_d      = dyn_q;
    sxn_d      = sxn_q;
    syn_d      = syn_q;
    err_d      = err_q;
    color_d    = color_q;
    rad_d      = rad_q;
    active_d   = active_q;
    done_d     = done_q;
    ox_d       = ox_q;
    oy_d       = oy_q;
    pend_v_d   = pend_v_q;
    pend_x_d   = pend_x_q;
    pend_y_d   = pend_y_q;
    out_v_d    = out_v_q && out_stall_i;
    out_x_d    = out_x_q;
    out_y_d    = out_y_q;
    out_c_d    = out_c_q;
    out_we_d   = out_we_q;
    out_last_d = out_last_q;
    out_done_d = out_done_q;
    cmd_pop_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == CMD_LOAD) begin
            cmd_pop_o = 1'b1;
            cur_x_d   = cmd_i.sx;
            cur_y_d   = cmd_i.sy;
            tgt_x_d   = cmd_i.ex;
            tgt_y_d   = cmd_i.ey;
            dx_d      = dx_ld;
            dyn_d     = -$signed({1'b0, dy_ld});
            sxn_d     = !(cmd_i.sx < cmd_i.ex);
            syn_d     = !(cmd_i.sy < cmd_i.ey);
            err_d     = $signed({2'b00, dx_ld}) - $signed({2'b00, dy_ld});
            color_d   = cmd_i.color;
            rad_d     = cmd_i.radius;
            active_d  = 1'b1;
          end else if (active_q) begin
            cmd_pop_o = 1'b1;
            ox_d      = -r_off;
            oy_d      = -r_off;
            pend_v_d  = 1'b0;
            done_d    = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
            state_d   = ST_SCAN;
          end else if (out_free) begin
            cmd_pop_o  = 1'b1;
            out_v_d    = 1'b1;
            out_x_d    = '0;
            out_y_d    = '0;
            out_c_d    = '0;
            out_we_d   = 1'b0;
            out_last_d = 1'b1;
            out_done_d = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (can_go) begin
          if (hit) begin
            if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_x_d    = pend_x_q;
              out_y_d    = pend_y_q;
              out_c_d    = color_q;
              out_we_d   = 1'b1;
              out_last_d = 1'b0;
              out_done_d = done_q;
            end
            pend_v_d = 1'b1;
            pend_x_d = px[COORD_W-1:0];
            pend_y_d = py[COORD_W-1:0];
          end
          if (last_off) begin
            state_d = ST_FINISH;
          end else if (ox_q == r_off) begin
            ox_d = -r_off;
            oy_d = oy_q + OFF_W'(1);
          end else begin
            ox_d = ox_q + OFF_W'(1);
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_x_d    = pend_v_q ? pend_x_q : '0;
          out_y_d    = pend_v_q ? pend_y_q : '0;
          out_c_d    = pend_v_q ? color_q : '0;
          out_we_d   = pend_v_q;
          out_last_d = 1'b1;
          out_done_d = done_q;
          pend_v_d   = 1'b0;
          state_d    = ST_IDLE;
          if (done_q) begin
            active_d = 1'b0;
          end else begin
            err_d = err_q
                    + (step_x ? ERR_W'(dyn_ext) : ERR_W'(0))
                    + (step_y ? ERR_W'(dx_ext) : ERR_W'(0));
            if (step_x) begin
              cur_x_d = sxn_q ? cur_x_q - COORD_W'(1) : cur_x_q + COORD_W'(1);
            end
            if (step_y) begin
              cur_y_d = syn_q ? cur_y_q - COORD_W'(1) : cur_y_q + COORD_W'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      tgt_x_q  <= '0;
      tgt_y_q  <= '0;
      dx_q     <= '0;
      dyn_q    <= '0;
      sxn_q    <= 1'b0;
      syn_q    <= 1'b0;
      err_q    <= '0;
      color_q  <= '0;
      rad_q    <= '0;
      active_q <= 1'b0;
      done_q   <= 1'b0;
      ox_q     <= '0;
      oy_q     <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      tgt_x_q  <= tgt_x_d;
      tgt_y_q  <= tgt_y_d;
      dx_q     <= dx_d;
      dyn_q    <= dyn_d;
      sxn_q    <= sxn_d;
      syn_q    <= syn_d;
      err_q    <= err_d;
      color_q  <= color_d;
      rad_q    <= rad_d;
      active_q <= active_d;
      done_q   <= done_d;
      ox_q     <= ox_d;
      oy_q     <= oy_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_x_q   <= pend_x_d;
    pend_y_q   <= pend_y_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_c_q    <= out_c_d;
    out_we_q   <= out_we_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
  end

  assign out_valid_o     = out_v_q;
  assign pixel_x_o       = out_x_q;
  assign pixel_y_o       = out_y_q;
  assign pixel_color_o   = out_c_q;
  assign write_enable_o  = out_we_q;
  assign last_of_point_o = out_last_q;
  assign line_done_o     = out_done_q;

endmodule

// ===== src/thick_line_rasterizer.sv =====
// load item: taken by the back engine without a result
// step item: every disc offset for brush radius r, one per cycle unless output
// back-pressure holds it, via the single offset scanner; idle step: no-write result
// up to two items wait in the command queue while a step is being scanned
// reset clears the line state (idle), the queue and the output register and
// sets the resolution register to 512
// ----------------------------------------------------------------------------
// thick_line_rasterizer
// bresenham line walker stamping a filled disc brush, clipped to a square
// buffer
// ----------------------------------------------------------------------------
module thick_line_rasterizer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tlr_pkg::RES_W-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [tlr_pkg::COORD_W-1:0]  start_x_i,
  input  logic [tlr_pkg::COORD_W-1:0]  start_y_i,
  input  logic [tlr_pkg::COORD_W-1:0]  end_x_i,
  input  logic [tlr_pkg::COORD_W-1:0]  end_y_i,
  input  logic [tlr_pkg::COLOR_W-1:0]  line_color_i,
  input  logic [tlr_pkg::RAD_W-1:0]    brush_radius_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tlr_pkg::COORD_W-1:0]  pixel_x_o,
  output logic [tlr_pkg::COORD_W-1:0]  pixel_y_o,
  output logic [tlr_pkg::COLOR_W-1:0]  pixel_color_o,
  output logic                         write_enable_o,
  output logic                         last_of_point_o,
  output logic                         line_done_o
);
  import tlr_pkg::*;

  logic [RES_W-1:0] res_q, res_clamped;
  logic             q_push, q_full, q_valid, q_pop;
  cmd_t             q_wcmd, q_rcmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= RES_W'(RES_RESET);
    end else if (cfg_we_i) begin
      res_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (res_q < RES_W'(MIN_RES)) begin
      res_clamped = RES_W'(MIN_RES);
    end else if (res_q > RES_W'(MAX_RES)) begin
      res_clamped = RES_W'(MAX_RES);
    end else begin
      res_clamped = res_q;
    end
  end

  tlr_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .line_color_i   (line_color_i),
    .brush_radius_i (brush_radius_i),
    .push_o         (q_push),
    .cmd_o          (q_wcmd),
    .full_i         (q_full)
  );

  tlr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_wcmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_rcmd),
    .pop_i   (q_pop)
  );

  tlr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_i           (q_rcmd),
    .cmd_pop_o       (q_pop),
    .res_i           (res_clamped),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_color_o   (pixel_color_o),
    .write_enable_o  (write_enable_o),
    .last_of_point_o (last_of_point_o),
    .line_done_o     (line_done_o)
  );

  // a result without a write always closes its step
  a_nowrite_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |-> last_of_point_o)
    else $error("result without write not marked last");

  // an empty queue never holds off the input
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_valid |-> !in_stall_o)
    else $error("input stalled with empty queue");

  // line_done stays the same across the results of one step
  a_done_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_point_o |=>
      !out_valid_o || (line_done_o == $past(line_done_o)))
    else $error("line_done changed within a step");

endmodule
